### hw/rtl/trht_pkg.sv
// trht_pkg: operation codes, output width and the control word shared by
// the hit tester top level and its window cells
// no dependencies
`timescale 1ns / 1ps

package trht_pkg;

  // operation codes of an input word
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_OPEN  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // width of the window number field
  localparam int unsigned OUT_NUM_W = 8;

  // chain-wide control, driven by the top level into every cell
  typedef struct packed {
    logic advance;  // query tokens step one cell down the chain
    logic shift;    // stored windows step one cell down the chain
    logic clear;    // every cell drops its window
  } trht_ctrl_t;

endpackage

### hw/rtl/topmost_rectangle_hit_test.sv
// Topmost rectangle hit tester.
// Input channel in_valid_i / in_ready_o carries one word: an opcode (clear,
// open or query), a point or window origin and, for open, the extents.
// Output channel out_valid_o / out_ready_i carries one word per query: the
// 1-based number of the most recently opened window holding the point, or 0.
// Windows sit in a chain of MAX_WINDOWS cells, newest at the head; an open
// pushes the whole chain down by one cell. A query becomes a token that
// walks the chain one cell per cycle while the chain is not stalled,
// newest to oldest, and keeps the first hit. Opens and queries are taken
// one per cycle unless the chain stalls, several queries in flight at
// once. An open with the chain full is dropped. A clear is held until no
// query token remains in the chain.
// Opcode 3 is taken and ignored. When a finished result waits in the output
// register and the next token reaches the chain tail, the whole chain and
// the input stall until out_ready_i is seen. Reset empties the window table
// and drops all tokens and results; no clearing pass is needed.
// depends on trht_pkg and trht_cell
`timescale 1ns / 1ps

module topmost_rectangle_hit_test #(
  parameter int unsigned MAX_WINDOWS = 128,
  parameter int unsigned COORD_BITS  = 20
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         opcode_i,
  input  logic [COORD_BITS-1:0]              row_i,
  input  logic [COORD_BITS-1:0]              col_i,
  input  logic [COORD_BITS:0]                row_extent_i,
  input  logic [COORD_BITS:0]                col_extent_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [trht_pkg::OUT_NUM_W-1:0]     window_number_o,
  output logic                               hit_o
);

  localparam int unsigned NUM_W = $clog2(MAX_WINDOWS + 1);
  localparam int unsigned SUM_W = COORD_BITS + 2;

  trht_pkg::trht_ctrl_t ctrl;

  // chain links: index 0 feeds the head cell, index k+1 leaves cell k
  logic [MAX_WINDOWS:0]  win_valid;
  logic [NUM_W-1:0]      win_num    [MAX_WINDOWS+1];
  logic [COORD_BITS-1:0] win_top    [MAX_WINDOWS+1];
  logic [COORD_BITS-1:0] win_left   [MAX_WINDOWS+1];
  logic [COORD_BITS-1:0] win_bottom [MAX_WINDOWS+1];
  logic [COORD_BITS-1:0] win_right  [MAX_WINDOWS+1];
  logic [MAX_WINDOWS:0]  tok_valid;
  logic [MAX_WINDOWS:0]  tok_found;
  logic [NUM_W-1:0]      tok_num    [MAX_WINDOWS+1];
  logic [COORD_BITS-1:0] tok_row    [MAX_WINDOWS+1];
  logic [COORD_BITS-1:0] tok_col    [MAX_WINDOWS+1];

  logic                  in_fire, any_tok, table_full, out_load;
  logic [COORD_BITS:0]   row_ext_eff, col_ext_eff;
  logic [SUM_W-1:0]      row_sum, col_sum;
  logic [COORD_BITS-1:0] row_end, col_end;
  logic [NUM_W+trht_pkg::OUT_NUM_W-1:0] num_wide;

  logic                  out_valid_q, out_valid_d;
  logic                  out_hit_q;
  logic [trht_pkg::OUT_NUM_W-1:0] out_num_q;

  // chain flow control
  assign any_tok    = |tok_valid[MAX_WINDOWS:1];
  assign table_full = win_valid[MAX_WINDOWS];
  assign ctrl.advance = !(tok_valid[MAX_WINDOWS] && out_valid_q && !out_ready_i);
  assign in_ready_o = ctrl.advance && !((opcode_i == trht_pkg::OP_CLEAR) && any_tok);
  assign in_fire    = in_valid_i && in_ready_o;
  assign ctrl.shift = in_fire && (opcode_i == trht_pkg::OP_OPEN) && !table_full;
  assign ctrl.clear = in_fire && (opcode_i == trht_pkg::OP_CLEAR);

  // end coordinates, zero extent counts as one, clamped to the maximum
  assign row_ext_eff = (row_extent_i == '0) ? (COORD_BITS+1)'(1) : row_extent_i;
  assign col_ext_eff = (col_extent_i == '0) ? (COORD_BITS+1)'(1) : col_extent_i;
  assign row_sum = {2'b00, row_i} + {1'b0, row_ext_eff} - SUM_W'(1);
  assign col_sum = {2'b00, col_i} + {1'b0, col_ext_eff} - SUM_W'(1);
  assign row_end = (row_sum[SUM_W-1:COORD_BITS] != 2'b00) ? '1 : row_sum[COORD_BITS-1:0];
  assign col_end = (col_sum[SUM_W-1:COORD_BITS] != 2'b00) ? '1 : col_sum[COORD_BITS-1:0];

  // head of the window chain: next number follows the newest stored one
  assign win_valid[0]  = 1'b1;
  assign win_num[0]    = win_valid[1] ? (win_num[1] + NUM_W'(1)) : NUM_W'(1);
  assign win_top[0]    = row_i;
  assign win_left[0]   = col_i;
  assign win_bottom[0] = row_end;
  assign win_right[0]  = col_end;

  // head of the token chain
  assign tok_valid[0] = in_fire && (opcode_i == trht_pkg::OP_QUERY);
  assign tok_found[0] = 1'b0;
  assign tok_num[0]   = '0;
  assign tok_row[0]   = row_i;
  assign tok_col[0]   = col_i;

  // row of window cells
  for (genvar k = 0; k < MAX_WINDOWS; k++) begin : g_cell
    trht_cell #(
      .COORD_BITS (COORD_BITS),
      .NUM_W      (NUM_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .win_valid_i  (win_valid[k]),
      .win_num_i    (win_num[k]),
      .win_top_i    (win_top[k]),
      .win_left_i   (win_left[k]),
      .win_bottom_i (win_bottom[k]),
      .win_right_i  (win_right[k]),
      .win_valid_o  (win_valid[k+1]),
      .win_num_o    (win_num[k+1]),
      .win_top_o    (win_top[k+1]),
      .win_left_o   (win_left[k+1]),
      .win_bottom_o (win_bottom[k+1]),
      .win_right_o  (win_right[k+1]),
      .tok_valid_i  (tok_valid[k]),
      .tok_found_i  (tok_found[k]),
      .tok_num_i    (tok_num[k]),
      .tok_row_i    (tok_row[k]),
      .tok_col_i    (tok_col[k]),
      .tok_valid_o  (tok_valid[k+1]),
      .tok_found_o  (tok_found[k+1]),
      .tok_num_o    (tok_num[k+1]),
      .tok_row_o    (tok_row[k+1]),
      .tok_col_o    (tok_col[k+1])
    );
  end

  // output register, loaded from the chain tail
  assign out_load = ctrl.advance && tok_valid[MAX_WINDOWS];
  assign num_wide = {{trht_pkg::OUT_NUM_W{1'b0}}, tok_num[MAX_WINDOWS]};

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_num_q <= num_wide[trht_pkg::OUT_NUM_W-1:0];
      out_hit_q <= tok_found[MAX_WINDOWS];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign window_number_o = out_num_q;
  assign hit_o           = out_hit_q;

  // a clear never overtakes a query still walking the chain
  a_clear_chain_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clear |-> !any_tok)
    else $error("clear taken with query tokens in flight");

  // a waiting result is never overwritten
  a_no_result_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !out_load)
    else $error("output register overwritten while stalled");

  // no window falls off the tail of a full chain
  a_no_shift_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.shift |-> !table_full)
    else $error("window chain shifted while full");

  // after a clear the head cell is empty
  a_clear_empties_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clear |=> !win_valid[1])
    else $error("head cell still valid after clear");

endmodule

### hw/rtl/trht_cell.sv
// trht_cell: one window slot of the hit tester chain plus one query token stage
// depends on trht_pkg (control word)
`timescale 1ns / 1ps

module trht_cell #(
  parameter int unsigned COORD_BITS = 20,
  parameter int unsigned NUM_W      = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  trht_pkg::trht_ctrl_t  ctrl_i,
  // window from the newer neighbour
  input  logic                  win_valid_i,
  input  logic [NUM_W-1:0]      win_num_i,
  input  logic [COORD_BITS-1:0] win_top_i,
  input  logic [COORD_BITS-1:0] win_left_i,
  input  logic [COORD_BITS-1:0] win_bottom_i,
  input  logic [COORD_BITS-1:0] win_right_i,
  // window held here, towards the older neighbour
  output logic                  win_valid_o,
  output logic [NUM_W-1:0]      win_num_o,
  output logic [COORD_BITS-1:0] win_top_o,
  output logic [COORD_BITS-1:0] win_left_o,
  output logic [COORD_BITS-1:0] win_bottom_o,
  output logic [COORD_BITS-1:0] win_right_o,
  // query token from the newer neighbour
  input  logic                  tok_valid_i,
  input  logic                  tok_found_i,
  input  logic [NUM_W-1:0]      tok_num_i,
  input  logic [COORD_BITS-1:0] tok_row_i,
  input  logic [COORD_BITS-1:0] tok_col_i,
  // token held here after the compare with this cell's window
  output logic                  tok_valid_o,
  output logic                  tok_found_o,
  output logic [NUM_W-1:0]      tok_num_o,
  output logic [COORD_BITS-1:0] tok_row_o,
  output logic [COORD_BITS-1:0] tok_col_o
);

  logic                  win_valid_q;
  logic [NUM_W-1:0]      win_num_q;
  logic [COORD_BITS-1:0] win_top_q, win_left_q, win_bottom_q, win_right_q;
  logic                  tok_valid_q, tok_found_q;
  logic [NUM_W-1:0]      tok_num_q;
  logic [COORD_BITS-1:0] tok_row_q, tok_col_q;
  logic                  hit;

  // window valid bit, emptied by a clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_valid_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      win_valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      win_valid_q <= win_valid_i;
    end
  end

  // window payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      win_num_q    <= win_num_i;
      win_top_q    <= win_top_i;
      win_left_q   <= win_left_i;
      win_bottom_q <= win_bottom_i;
      win_right_q  <= win_right_i;
    end
  end

  // token valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else if (ctrl_i.advance) begin
      tok_valid_q <= tok_valid_i;
    end
  end

  // token payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      tok_found_q <= tok_found_i;
      tok_num_q   <= tok_num_i;
      tok_row_q   <= tok_row_i;
      tok_col_q   <= tok_col_i;
    end
  end

  // containment test against the window held here
  assign hit = win_valid_q
             && (tok_row_q >= win_top_q)  && (tok_row_q <= win_bottom_q)
             && (tok_col_q >= win_left_q) && (tok_col_q <= win_right_q);

  // first hit along the chain is the topmost window
  assign tok_valid_o = tok_valid_q;
  assign tok_found_o = tok_found_q | hit;
  assign tok_num_o   = tok_found_q ? tok_num_q : (hit ? win_num_q : '0);
  assign tok_row_o   = tok_row_q;
  assign tok_col_o   = tok_col_q;

  assign win_valid_o  = win_valid_q;
  assign win_num_o    = win_num_q;
  assign win_top_o    = win_top_q;
  assign win_left_o   = win_left_q;
  assign win_bottom_o = win_bottom_q;
  assign win_right_o  = win_right_q;

endmodule

### verif/tb.sv
// tb: self-checking testbench for the topmost rectangle hit tester
// keeps its own window table to predict each query answer; depends on trht_pkg
// and topmost_rectangle_hit_test
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MAX_WINDOWS = 128;
  localparam int unsigned COORD_BITS  = 20;
  localparam logic [COORD_BITS-1:0] CMAX = '1;
  localparam longint unsigned COORD_LIMIT = (64'd1 << COORD_BITS) - 64'd1;
  // opcode 3 is taken by the block and ignored
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned RANDOM_WORDS = 1200;
  localparam int unsigned AIM_DEPTH = 256;

  // one input word plus its pacing
  typedef struct packed {
    logic [1:0]            opcode;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS:0]   row_extent;
    logic [COORD_BITS:0]   col_extent;
    bit                    drain_first;  // hold until every answer is back
    int unsigned           gap_after;    // idle cycles after acceptance
  } word_t;

  typedef struct packed {
    logic [trht_pkg::OUT_NUM_W-1:0] window_number;
    logic                           hit;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  word_t shown = '0;
  logic in_ready_o;
  logic out_valid_o;
  logic [trht_pkg::OUT_NUM_W-1:0] window_number_o;
  logic hit_o;

  word_t   words_to_send[$];
  answer_t answers_due[$];
  int unsigned mismatch_count = 0;

  // predicted desktop
  logic [COORD_BITS-1:0] desk_top[MAX_WINDOWS];
  logic [COORD_BITS-1:0] desk_left[MAX_WINDOWS];
  logic [COORD_BITS-1:0] desk_bottom[MAX_WINDOWS];
  logic [COORD_BITS-1:0] desk_right[MAX_WINDOWS];
  int unsigned desk_count = 0;

  // windows opened by the stimulus, used to aim queries
  logic [COORD_BITS-1:0] aim_row[AIM_DEPTH];
  logic [COORD_BITS-1:0] aim_col[AIM_DEPTH];
  logic [COORD_BITS:0]   aim_rext[AIM_DEPTH];
  logic [COORD_BITS:0]   aim_cext[AIM_DEPTH];
  int unsigned aim_n = 0;
  int unsigned useful_words = 0;
  bit drain_next = 1'b0;

  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  logic [31:0] cycle_no = '0;

  topmost_rectangle_hit_test #(
    .MAX_WINDOWS(MAX_WINDOWS),
    .COORD_BITS (COORD_BITS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .opcode_i       (shown.opcode),
    .row_i          (shown.row),
    .col_i          (shown.col),
    .row_extent_i   (shown.row_extent),
    .col_extent_i   (shown.col_extent),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .window_number_o(window_number_o),
    .hit_o          (hit_o)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // inclusive end of a window edge, zero extent counts as one
  function automatic logic [COORD_BITS-1:0] edge_end(logic [COORD_BITS-1:0] start,
                                                     logic [COORD_BITS:0] extent);
    longint unsigned span;
    longint unsigned last;
    span = (extent == '0) ? 64'd1 : 64'(extent);
    last = 64'(start) + span - 64'd1;
    return (last > COORD_LIMIT) ? CMAX : last[COORD_BITS-1:0];
  endfunction

  // apply one accepted word to the predicted desktop
  function automatic void take_word(word_t w);
    int unsigned i;
    int unsigned found;
    answer_t a;
    found = 0;
    case (w.opcode)
      trht_pkg::OP_CLEAR: desk_count = 0;
      trht_pkg::OP_OPEN: begin
        if (desk_count < MAX_WINDOWS) begin
          desk_top[desk_count]    = w.row;
          desk_left[desk_count]   = w.col;
          desk_bottom[desk_count] = edge_end(w.row, w.row_extent);
          desk_right[desk_count]  = edge_end(w.col, w.col_extent);
          desk_count++;
        end
      end
      trht_pkg::OP_QUERY: begin
        // newest window first, first hit wins
        for (i = desk_count; i > 0 && found == 0; i--) begin
          if (w.row >= desk_top[i-1] && w.row <= desk_bottom[i-1] &&
              w.col >= desk_left[i-1] && w.col <= desk_right[i-1]) begin
            found = i;
          end
        end
        a.window_number = found[trht_pkg::OUT_NUM_W-1:0];
        a.hit = (found != 0);
        answers_due.insert(answers_due.size(), a);
      end
      default: ;
    endcase
  endfunction

  function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  // stimulus helpers
  function automatic void queue_word(logic [1:0] op, logic [COORD_BITS-1:0] row,
                                     logic [COORD_BITS-1:0] col,
                                     logic [COORD_BITS:0] rext, logic [COORD_BITS:0] cext);
    word_t w;
    w.opcode = op;
    w.row = row;
    w.col = col;
    w.row_extent = rext;
    w.col_extent = cext;
    w.drain_first = drain_next;
    w.gap_after = 0;
    drain_next = 1'b0;
    words_to_send.insert(words_to_send.size(), w);
    if (op != OP_UNUSED) useful_words++;
    if (op == trht_pkg::OP_CLEAR) aim_n = 0;
    if (op == trht_pkg::OP_OPEN && aim_n < AIM_DEPTH) begin
      aim_row[aim_n] = row;
      aim_col[aim_n] = col;
      aim_rext[aim_n] = rext;
      aim_cext[aim_n] = cext;
      aim_n++;
    end
  endfunction

  // a coordinate on, just inside or just outside one edge of a window
  function automatic logic [COORD_BITS-1:0] pick_coord(logic [COORD_BITS-1:0] start,
                                                       logic [COORD_BITS:0] extent);
    int unsigned span;
    span = (extent == '0) ? 1 : extent;
    case ($urandom_range(0, 4))
      0: return start;
      1: return start + span - 1;
      2: return start + span;
      3: return start - 1;
      default: return start + $urandom_range(0, span - 1);
    endcase
  endfunction

  function automatic void open_in_area(logic [COORD_BITS-1:0] base, int unsigned span);
    logic [COORD_BITS:0] rext;
    logic [COORD_BITS:0] cext;
    if ($urandom_range(0, 15) == 0) begin
      rext = $urandom;
      cext = $urandom;
    end else begin
      rext = $urandom_range(1, span);
      cext = $urandom_range(1, span);
    end
    if ($urandom_range(0, 31) == 0) rext = '0;
    if ($urandom_range(0, 31) == 0) cext = '0;
    queue_word(trht_pkg::OP_OPEN, base + $urandom_range(0, span - 1),
               base + $urandom_range(0, span - 1), rext, cext);
  endfunction

  function automatic void query_in_area(logic [COORD_BITS-1:0] base, int unsigned span);
    int unsigned j;
    if (aim_n == 0 || $urandom_range(0, 7) == 0) begin
      queue_word(trht_pkg::OP_QUERY, base + $urandom_range(0, span - 1),
                 base + $urandom_range(0, span - 1), $urandom, $urandom);
    end else begin
      j = $urandom_range(0, aim_n - 1);
      queue_word(trht_pkg::OP_QUERY, pick_coord(aim_row[j], aim_rext[j]),
                 pick_coord(aim_col[j], aim_cext[j]), $urandom, $urandom);
    end
  endfunction

  // stimulus: directed words, then random desktop sessions
  initial begin : fill_words
    logic [COORD_BITS-1:0] base;
    int unsigned span;
    int unsigned len;
    int unsigned pick;
    int unsigned i;

    queue_word(trht_pkg::OP_QUERY, 0, 0, 1, 1);
    queue_word(OP_UNUSED, CMAX, CMAX, '1, '1);
    queue_word(trht_pkg::OP_OPEN, 0, 0, 1, 1);
    queue_word(trht_pkg::OP_QUERY, 0, 0, 0, 0);
    queue_word(trht_pkg::OP_QUERY, 0, 1, 0, 0);
    queue_word(trht_pkg::OP_QUERY, 1, 0, 0, 0);
    // full-width extents, clamped at the coordinate maximum
    queue_word(trht_pkg::OP_OPEN, CMAX, CMAX, '1, '1);
    queue_word(trht_pkg::OP_QUERY, CMAX, CMAX, 0, 0);
    queue_word(trht_pkg::OP_QUERY, CMAX - 1, CMAX, 0, 0);
    // zero extent behaves as one
    queue_word(trht_pkg::OP_OPEN, 0, 0, 0, 0);
    queue_word(trht_pkg::OP_QUERY, 0, 0, 0, 0);
    queue_word(trht_pkg::OP_QUERY, 1, 1, 0, 0);
    queue_word(trht_pkg::OP_OPEN, 100, 200, 21'h100000, 21'h100000);
    queue_word(trht_pkg::OP_QUERY, CMAX, CMAX, 0, 0);
    queue_word(trht_pkg::OP_QUERY, 100, 200, 0, 0);
    queue_word(trht_pkg::OP_QUERY, 99, 200, 0, 0);
    queue_word(trht_pkg::OP_QUERY, 100, 199, 0, 0);
    queue_word(trht_pkg::OP_OPEN, 5, 5, 10, 10);
    queue_word(trht_pkg::OP_QUERY, 14, 14, 0, 0);
    queue_word(trht_pkg::OP_QUERY, 15, 14, 0, 0);
    queue_word(OP_UNUSED, 0, 0, 0, 0);
    queue_word(trht_pkg::OP_QUERY, 5, 5, 0, 0);
    drain_next = 1'b1;
    queue_word(trht_pkg::OP_CLEAR, CMAX, CMAX, '1, '1);
    queue_word(trht_pkg::OP_QUERY, CMAX, CMAX, 0, 0);

    useful_words = 0;
    while (useful_words < RANDOM_WORDS) begin
      case ($urandom_range(0, 3))
        0: begin base = 0; span = 16; end
        1: begin base = $urandom; span = 256; end
        2: begin base = CMAX - 255; span = 256; end
        default: begin base = 0; span = 1 << COORD_BITS; end
      endcase
      if ($urandom_range(0, 9) == 0) drain_next = 1'b1;
      if ($urandom_range(0, 9) != 0) begin
        queue_word(trht_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
      end
      // now and then run the table past full
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(120, 140)) open_in_area(base, span);
      end
      len = $urandom_range(4, 40);
      repeat (len) begin
        pick = $urandom_range(0, 99);
        if (pick < 2) queue_word(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
        else if (pick < 35) open_in_area(base, span);
        else query_in_area(base, span);
      end
    end

    // sender gaps, with calm stretches and a calm tail
    for (i = 0; i < words_to_send.size(); i++) begin
      if ((i / 50) % 4 == 3 || i + 150 >= words_to_send.size()) begin
        words_to_send[i].gap_after = 0;
      end else if ($urandom_range(0, 4) == 0) begin
        words_to_send[i].gap_after = $urandom_range(1, 3);
      end
    end
  end

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      shown <= '0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready_o) take_word(shown);
      if (!in_valid || in_ready_o) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (words_to_send.size() == 0) begin
          in_valid <= 1'b0;
        end else if (words_to_send[0].drain_first && answers_due.size() != 0) begin
          in_valid <= 1'b0;
        end else begin
          shown <= words_to_send[0];
          gap_left <= words_to_send[0].gap_after;
          in_valid <= 1'b1;
          words_to_send.delete(0);
        end
      end
    end
  end

  // result monitor and receiver stalls, none in calm stretches or near the end
  always @(posedge clk_i or negedge rst_ni) begin : rx_check
    answer_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      cycle_no <= '0;
    end else begin
      cycle_no <= cycle_no + 1;
      if (out_valid_o && out_ready) begin
        if (answers_due.size() == 0) begin
          note_mismatch("result word with none pending", 0, window_number_o);
        end else begin
          want = answers_due.pop_front();
          if (window_number_o !== want.window_number) begin
            note_mismatch("window_number", want.window_number, window_number_o);
          end
          if (hit_o !== want.hit) begin
            note_mismatch("hit", want.hit, hit_o);
          end
        end
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (cycle_no[9:8] != 2'b11 && words_to_send.size() >= 150 &&
                   $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        stall_left <= $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // end of run once every word is in and every answer is back
  initial begin : run_end
    wait (rst_ni);
    while (words_to_send.size() != 0 || in_valid) @(posedge clk_i);
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (MAX_WINDOWS + 20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #16_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
